/* src/lbmp_pkg.sv */
package lbmp_pkg;

  // field widths
  localparam int POS_W   = 16;
  localparam int DRIVE_W = 9;
  localparam int CFG_W   = 16;

  // limit range and pwm resolution
  localparam int POS_BITS = 10;
  localparam int PWM_BITS = 8;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [PWM_BITS-1:0] PWM_MAX = '1;

  // stream word widths, padded to whole bytes
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  // register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEEK      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEEK      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SENSE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_ENABLE  = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] MIN_SEEK_RST = 16'd0;
  localparam logic [CFG_W-1:0] MAX_SEEK_RST = 16'd1023;

  // request kinds carried in tuser
  localparam logic REQ_DRIVE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] min_seek;
    logic [CFG_W-1:0] max_seek;
    logic             reverse_sense;
    logic             drive_enable;
  } cfg_t;

endpackage

/* src/lbmp_drive_calc.sv */
module lbmp_drive_calc (
  input  lbmp_pkg::cfg_t                          cfg,
  input  logic [lbmp_pkg::POS_W-1:0]              position,
  input  logic signed [lbmp_pkg::DRIVE_W-1:0]     drive,
  output logic [lbmp_pkg::PWM_BITS-1:0]           cw_width,
  output logic [lbmp_pkg::PWM_BITS-1:0]           ccw_width
);

  logic [lbmp_pkg::POS_BITS-1:0] min_c;
  logic [lbmp_pkg::POS_BITS-1:0] max_c;
  logic [lbmp_pkg::POS_BITS-1:0] lo;
  logic [lbmp_pkg::POS_BITS-1:0] hi;
  logic [lbmp_pkg::DRIVE_W-1:0]  raw;
  logic [lbmp_pkg::DRIVE_W-1:0]  mag;
  logic [lbmp_pkg::PWM_BITS-1:0] sat;
  logic                          neg;
  logic                          pos_dir;
  logic                          blocked;

  // clamp the limits, swap and mirror them in reverse mode
  always_comb begin
    min_c = (cfg.min_seek > lbmp_pkg::POS_W'(lbmp_pkg::POS_MAX)) ?
            lbmp_pkg::POS_MAX : cfg.min_seek[lbmp_pkg::POS_BITS-1:0];
    max_c = (cfg.max_seek > lbmp_pkg::POS_W'(lbmp_pkg::POS_MAX)) ?
            lbmp_pkg::POS_MAX : cfg.max_seek[lbmp_pkg::POS_BITS-1:0];
    if (cfg.reverse_sense) begin
      lo = lbmp_pkg::POS_MAX - max_c;
      hi = lbmp_pkg::POS_MAX - min_c;
    end else begin
      lo = min_c;
      hi = max_c;
    end
  end

  // direction, limit gating and saturated magnitude
  always_comb begin
    raw     = drive;
    neg     = raw[lbmp_pkg::DRIVE_W-1];
    pos_dir = !neg && (|raw);
    blocked = !cfg.drive_enable
           || (neg && (position < lbmp_pkg::POS_W'(lo)))
           || (pos_dir && (position > lbmp_pkg::POS_W'(hi)));
    // -256 becomes 256 here, which fits the unsigned 9-bit range
    mag = neg ? lbmp_pkg::DRIVE_W'(~raw + lbmp_pkg::DRIVE_W'(1)) : raw;
    sat = (mag > lbmp_pkg::DRIVE_W'(lbmp_pkg::PWM_MAX)) ?
          lbmp_pkg::PWM_MAX : mag[lbmp_pkg::PWM_BITS-1:0];
    cw_width  = (!blocked && neg)     ? sat : '0;
    ccw_width = (!blocked && pos_dir) ? sat : '0;
  end

endmodule

/* src/limited_bidirectional_motor_pwm_core.sv */
// Two-direction bridge PWM with soft position limits.
// Throughput: one word per cycle while m_tready does not stall the output; input
// register and result register form a two-stage pipeline and the widths and
// counter update in the second stage.
// Reset (rst, synchronous, active high) clears widths, counter and valids and
// loads the registers with min 0, max 1023, normal sense, drive enabled.
module limited_bidirectional_motor_pwm_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // position [15:0], drive [24:16], zero pad [31:25]
  input  logic [lbmp_pkg::S_TDATA_W-1:0]   s_tdata,
  // req_type
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // cw_level [7:0], ccw_level [15:8], cw_pin [16], ccw_pin [17], zero pad [23:18]
  output logic [lbmp_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lbmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbmp_pkg::CFG_W-1:0]       cfg_data
);

  lbmp_pkg::cfg_t cfg;

  logic                                   in_valid;
  logic                                   in_tick;
  logic [lbmp_pkg::POS_W-1:0]             in_position;
  logic signed [lbmp_pkg::DRIVE_W-1:0]    in_drive;

  logic [lbmp_pkg::PWM_BITS-1:0]          cw_store;
  logic [lbmp_pkg::PWM_BITS-1:0]          ccw_store;
  logic [lbmp_pkg::PWM_BITS-1:0]          pwm_count;

  logic [lbmp_pkg::PWM_BITS-1:0]          calc_cw;
  logic [lbmp_pkg::PWM_BITS-1:0]          calc_ccw;
  logic [lbmp_pkg::PWM_BITS-1:0]          cw_next;
  logic [lbmp_pkg::PWM_BITS-1:0]          ccw_next;

  logic [lbmp_pkg::PWM_BITS-1:0]          cw_level;
  logic [lbmp_pkg::PWM_BITS-1:0]          ccw_level;
  logic                                   cw_pin;
  logic                                   ccw_pin;

  logic                                   advance;

  // pipeline handshake
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_seek      <= lbmp_pkg::MIN_SEEK_RST;
      cfg.max_seek      <= lbmp_pkg::MAX_SEEK_RST;
      cfg.reverse_sense <= 1'b0;
      cfg.drive_enable  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbmp_pkg::REG_MIN_SEEK:      cfg.min_seek      <= cfg_data;
        lbmp_pkg::REG_MAX_SEEK:      cfg.max_seek      <= cfg_data;
        lbmp_pkg::REG_REVERSE_SENSE: cfg.reverse_sense <= cfg_data[0];
        lbmp_pkg::REG_DRIVE_ENABLE:  cfg.drive_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_tick     <= (s_tuser == lbmp_pkg::REQ_TICK);
      in_position <= s_tdata[lbmp_pkg::POS_W-1:0];
      in_drive    <= $signed(s_tdata[lbmp_pkg::POS_W +: lbmp_pkg::DRIVE_W]);
    end
  end

  lbmp_drive_calc u_drive_calc (
    .cfg       (cfg),
    .position  (in_position),
    .drive     (in_drive),
    .cw_width  (calc_cw),
    .ccw_width (calc_ccw)
  );

  // widths after this word: ticks keep the stored widths
  assign cw_next  = in_tick ? cw_store  : calc_cw;
  assign ccw_next = in_tick ? ccw_store : calc_ccw;

  // width and counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      cw_store  <= '0;
      ccw_store <= '0;
      pwm_count <= '0;
    end else if (advance) begin
      cw_store  <= cw_next;
      ccw_store <= ccw_next;
      if (in_tick) begin
        pwm_count <= pwm_count + lbmp_pkg::PWM_BITS'(1);
      end
    end
  end

  // result register, pins from the counter before it advances
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cw_level  <= cw_next;
      ccw_level <= ccw_next;
      cw_pin    <= (pwm_count < cw_next);
      ccw_pin   <= (pwm_count < ccw_next);
    end
  end

  assign m_tdata = {(lbmp_pkg::M_TDATA_W - 2 * lbmp_pkg::PWM_BITS - 2)'(0),
                    ccw_pin, cw_pin, ccw_level, cw_level};

`ifndef SYNTHESIS
  // only one bridge half is ever driven
  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    !((cw_store != '0) && (ccw_store != '0)))
    else $error("both bridge widths nonzero");

  // a pin can only be high with a nonzero width
  a_pin_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (cw_pin || ccw_pin) |->
      ((cw_pin && (cw_level != '0)) || (!cw_pin && (ccw_level != '0))))
    else $error("pin high with zero width");

  // counter steps by one on each tick
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance && in_tick |=>
      pwm_count == lbmp_pkg::PWM_BITS'($past(pwm_count) + lbmp_pkg::PWM_BITS'(1)))
    else $error("pwm counter did not advance on tick");

  // disabled drive always stops the bridge
  a_disabled_stop: assert property (@(posedge clk) disable iff (rst)
    advance && !in_tick && !cfg.drive_enable |=>
      (cw_store == '0) && (ccw_store == '0))
    else $error("drive not stopped while disabled");
`endif

endmodule
